FILE: hw/rtl/kss_pkg.sv
`timescale 1ns / 1ps

package kss_pkg;

    localparam int QUEUE_DEPTH = 32;
    localparam int NUM_CLASSES = 4;
    localparam int PTR_W       = $clog2(QUEUE_DEPTH);
    localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
    localparam int SUM_W       = $clog2(QUEUE_DEPTH * 255 + 1);
    localparam int DSTEP_W     = $clog2(SUM_W + 1);

    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_ADDR_W-1:0] CFG_WINDOW   = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_MIN      = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_SUPPRESS = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] CFG_THR0     = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] CFG_THR1     = 3'd4;
    localparam logic [CFG_ADDR_W-1:0] CFG_THR2     = 3'd5;
    localparam logic [CFG_ADDR_W-1:0] CFG_THR3     = 3'd6;

    localparam logic [15:0] WINDOW_RST   = 16'd1000;
    localparam logic [5:0]  MIN_RST      = 6'd3;
    localparam logic [15:0] SUPPRESS_RST = 16'd1500;
    localparam logic [NUM_CLASSES-1:0][7:0] THR_RST = {8'd180, 8'd180, 8'd215, 8'd200};

    typedef struct packed {
        logic [NUM_CLASSES-1:0][7:0] score;
        logic [31:0]                 tm;
    } t_entry;

    typedef struct packed {
        logic load;
        logic store;
        logic pop;
        logic sum_init;
        logic sum_step;
        logic div_init;
        logic div_step;
        logic set_err;
        logic set_undec;
        logic set_fin;
        logic emit;
    } t_kss_cmd;

    typedef struct packed {
        logic             order_err;
        logic             prune;
        logic             undec;
        logic             sum_done;
        logic             div_done;
        logic             out_free;
        logic [CNT_W-1:0] count;
    } t_kss_sts;

    function automatic logic [PTR_W-1:0] kss_next(input logic [PTR_W-1:0] p);
        kss_next = (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + PTR_W'(1);
    endfunction

endpackage

FILE: hw/rtl/kss_ctrl.sv
`timescale 1ns / 1ps

module kss_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              s_axis_tvalid,
    output logic              s_axis_tready,
    input  kss_pkg::t_kss_sts i_sts,
    output kss_pkg::t_kss_cmd o_cmd
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_CHK  = 3'd1;
    localparam logic [2:0] S_PRD  = 3'd2;
    localparam logic [2:0] S_PCHK = 3'd3;
    localparam logic [2:0] S_SUM  = 3'd4;
    localparam logic [2:0] S_DIV  = 3'd5;
    localparam logic [2:0] S_FIN  = 3'd6;
    localparam logic [2:0] S_OUT  = 3'd7;

    logic [2:0] r_state;
    logic [2:0] n_state;

    assign s_axis_tready = (r_state == S_IDLE);

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (s_axis_tvalid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_CHK;
                end
            end
            S_CHK: begin
                if (i_sts.order_err) begin
                    o_cmd.set_err = 1'b1;
                    n_state       = S_OUT;
                end else begin
                    o_cmd.store = 1'b1;
                    n_state     = S_PRD;
                end
            end
            S_PRD: begin
                n_state = S_PCHK;
            end
            S_PCHK: begin
                if (i_sts.prune) begin
                    o_cmd.pop = 1'b1;
                    n_state   = S_PRD;
                end else if (i_sts.undec) begin
                    o_cmd.set_undec = 1'b1;
                    n_state         = S_OUT;
                end else begin
                    o_cmd.sum_init = 1'b1;
                    n_state        = S_SUM;
                end
            end
            S_SUM: begin
                if (i_sts.sum_done) begin
                    o_cmd.div_init = 1'b1;
                    n_state        = S_DIV;
                end else begin
                    o_cmd.sum_step = 1'b1;
                end
            end
            S_DIV: begin
                if (i_sts.div_done) begin
                    n_state = S_FIN;
                end else begin
                    o_cmd.div_step = 1'b1;
                end
            end
            S_FIN: begin
                o_cmd.set_fin = 1'b1;
                n_state       = S_OUT;
            end
            S_OUT: begin
                if (i_sts.out_free) begin
                    o_cmd.emit = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

FILE: hw/rtl/kss_dp.sv
`timescale 1ns / 1ps

module kss_dp (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic [63:0]                        i_in_data,
    input  logic                               i_cfg_we,
    input  logic [kss_pkg::CFG_ADDR_W-1:0]     i_cfg_addr,
    input  logic [kss_pkg::CFG_DATA_W-1:0]     i_cfg_wdata,
    input  kss_pkg::t_kss_cmd                  i_cmd,
    output kss_pkg::t_kss_sts                  o_sts,
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    output logic [15:0]                        m_axis_tdata
);

    localparam int NC = kss_pkg::NUM_CLASSES;

    // configuration
    logic [15:0]        r_window;
    logic [5:0]         r_min;
    logic [15:0]        r_suppress;
    logic [NC-1:0][7:0] r_thr;

    // queue
    kss_pkg::t_entry r_mem [kss_pkg::QUEUE_DEPTH];
    kss_pkg::t_entry r_rdata;
    logic [kss_pkg::PTR_W-1:0] r_ptr;
    logic [kss_pkg::CNT_W-1:0] r_cnt;
    logic [kss_pkg::PTR_W-1:0] w_rd_addr;
    logic [kss_pkg::PTR_W-1:0] w_slot;
    logic [kss_pkg::CNT_W:0]   w_slot_sum;
    logic                      w_full;

    // current item
    logic [31:0]        r_t;
    logic [NC-1:0][7:0] r_sc;

    // averaging
    logic [kss_pkg::PTR_W-1:0]   r_idx;
    logic [kss_pkg::CNT_W-1:0]   r_k;
    logic                        r_rvld;
    logic [kss_pkg::SUM_W-1:0]   r_sum [NC];
    logic [kss_pkg::CNT_W-1:0]   r_rem [NC];
    logic [kss_pkg::SUM_W-1:0]   r_quo [NC];
    logic [kss_pkg::DSTEP_W-1:0] r_dstep;
    logic [kss_pkg::CNT_W-1:0]   n_rem [NC];
    logic [kss_pkg::SUM_W-1:0]   n_quo [NC];

    // command tracking
    logic [1:0]         r_last_label;
    logic signed [32:0] r_lct;

    // result
    logic [1:0]  r_res_label;
    logic [7:0]  r_res_avg;
    logic        r_res_new;
    logic        r_res_err;
    logic        r_m_tvalid;
    logic [15:0] r_m_tdata;

    logic signed [32:0] w_t33;
    logic signed [32:0] w_ent33;
    logic signed [32:0] w_limit;
    logic signed [32:0] w_span;
    logic signed [33:0] w_since;
    logic [1:0]         w_top;
    logic [7:0]         w_top_score;
    logic               w_fresh;

    assign w_t33   = {r_t[31], r_t};
    assign w_ent33 = {r_rdata.tm[31], r_rdata.tm};
    assign w_limit = w_t33 - $signed({17'd0, r_window});
    assign w_span  = w_t33 - w_ent33;
    assign w_since = {w_t33[32], w_t33} - {r_lct[32], r_lct};

    assign w_full     = (r_cnt == kss_pkg::CNT_W'(kss_pkg::QUEUE_DEPTH));
    assign w_slot_sum = {{(kss_pkg::CNT_W + 1 - kss_pkg::PTR_W){1'b0}}, r_ptr}
                        + {1'b0, r_cnt};
    assign w_slot     = (w_slot_sum >= (kss_pkg::CNT_W + 1)'(kss_pkg::QUEUE_DEPTH))
                        ? kss_pkg::PTR_W'(w_slot_sum
                          - (kss_pkg::CNT_W + 1)'(kss_pkg::QUEUE_DEPTH))
                        : kss_pkg::PTR_W'(w_slot_sum);
    assign w_rd_addr  = i_cmd.sum_step ? r_idx : r_ptr;

    assign o_sts.order_err = (r_cnt != '0) && ($signed(r_t) < $signed(r_rdata.tm));
    assign o_sts.prune     = (r_cnt != '0) && (w_ent33 < w_limit);
    assign o_sts.undec     = (32'(r_cnt) < 32'(r_min))
                             || (w_span < $signed({19'd0, r_window[15:2]}));
    assign o_sts.sum_done  = (r_k == r_cnt) && !r_rvld;
    assign o_sts.div_done  = (r_dstep == kss_pkg::DSTEP_W'(kss_pkg::SUM_W));
    assign o_sts.out_free  = !r_m_tvalid || m_axis_tready;
    assign o_sts.count     = r_cnt;

    // restoring divide, one quotient bit per step in every lane
    always_comb begin
        logic [kss_pkg::CNT_W:0] rem_sh;
        logic [kss_pkg::CNT_W:0] dsr;
        dsr = {1'b0, r_cnt};
        for (int i = 0; i < NC; i++) begin
            rem_sh = {r_rem[i], r_quo[i][kss_pkg::SUM_W-1]};
            if (rem_sh >= dsr) begin
                n_rem[i] = kss_pkg::CNT_W'(rem_sh - dsr);
                n_quo[i] = {r_quo[i][kss_pkg::SUM_W-2:0], 1'b1};
            end else begin
                n_rem[i] = kss_pkg::CNT_W'(rem_sh);
                n_quo[i] = {r_quo[i][kss_pkg::SUM_W-2:0], 1'b0};
            end
        end
    end

    // first largest average
    always_comb begin
        w_top       = 2'd0;
        w_top_score = 8'd0;
        for (int i = 0; i < NC; i++) begin
            if (r_quo[i][7:0] > w_top_score) begin
                w_top_score = r_quo[i][7:0];
                w_top       = 2'(i);
            end
        end
        w_fresh = (w_top_score > r_thr[w_top])
                  && ((w_top != r_last_label) || (w_since > $signed({18'd0, r_suppress})));
    end

    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[w_rd_addr];
        if (i_cmd.store) begin
            r_mem[w_slot] <= '{score: r_sc, tm: r_t};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window     <= kss_pkg::WINDOW_RST;
            r_min        <= kss_pkg::MIN_RST;
            r_suppress   <= kss_pkg::SUPPRESS_RST;
            r_thr        <= kss_pkg::THR_RST;
            r_ptr        <= '0;
            r_cnt        <= '0;
            r_last_label <= 2'd0;
            r_lct        <= {1'b1, 32'd0};
            r_rvld       <= 1'b0;
            r_m_tvalid   <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_addr)
                    kss_pkg::CFG_WINDOW:   r_window   <= i_cfg_wdata;
                    kss_pkg::CFG_MIN:      r_min      <= i_cfg_wdata[5:0];
                    kss_pkg::CFG_SUPPRESS: r_suppress <= i_cfg_wdata;
                    kss_pkg::CFG_THR0:     r_thr[0]   <= i_cfg_wdata[7:0];
                    kss_pkg::CFG_THR1:     r_thr[1]   <= i_cfg_wdata[7:0];
                    kss_pkg::CFG_THR2:     r_thr[2]   <= i_cfg_wdata[7:0];
                    kss_pkg::CFG_THR3:     r_thr[3]   <= i_cfg_wdata[7:0];
                    default: ;
                endcase
            end
            if (i_cmd.store) begin
                if (w_full) begin
                    r_ptr <= kss_pkg::kss_next(r_ptr);
                end else begin
                    r_cnt <= r_cnt + kss_pkg::CNT_W'(1);
                end
            end else if (i_cmd.pop) begin
                r_ptr <= kss_pkg::kss_next(r_ptr);
                r_cnt <= r_cnt - kss_pkg::CNT_W'(1);
            end
            r_rvld <= i_cmd.sum_step && (r_k != r_cnt);
            if (i_cmd.set_fin && w_fresh) begin
                r_last_label <= w_top;
                r_lct        <= w_t33;
            end
            if (i_cmd.emit) begin
                r_m_tvalid <= 1'b1;
            end else if (m_axis_tready) begin
                r_m_tvalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_t  <= i_in_data[31:0];
            r_sc <= i_in_data[63:32];
        end
        if (i_cmd.sum_init) begin
            r_idx <= r_ptr;
            r_k   <= '0;
            for (int i = 0; i < NC; i++) begin
                r_sum[i] <= '0;
            end
        end else begin
            if (i_cmd.sum_step && (r_k != r_cnt)) begin
                r_idx <= kss_pkg::kss_next(r_idx);
                r_k   <= r_k + kss_pkg::CNT_W'(1);
            end
            if (r_rvld) begin
                for (int i = 0; i < NC; i++) begin
                    r_sum[i] <= r_sum[i] + kss_pkg::SUM_W'({~r_rdata.score[i][7],
                                                            r_rdata.score[i][6:0]});
                end
            end
        end
        if (i_cmd.div_init) begin
            r_dstep <= '0;
            for (int i = 0; i < NC; i++) begin
                r_quo[i] <= r_sum[i];
                r_rem[i] <= '0;
            end
        end else if (i_cmd.div_step) begin
            r_dstep <= r_dstep + kss_pkg::DSTEP_W'(1);
            for (int i = 0; i < NC; i++) begin
                r_quo[i] <= n_quo[i];
                r_rem[i] <= n_rem[i];
            end
        end
        if (i_cmd.set_err) begin
            r_res_label <= 2'd0;
            r_res_avg   <= 8'd0;
            r_res_new   <= 1'b0;
            r_res_err   <= 1'b1;
        end else if (i_cmd.set_undec) begin
            r_res_label <= r_last_label;
            r_res_avg   <= 8'd0;
            r_res_new   <= 1'b0;
            r_res_err   <= 1'b0;
        end else if (i_cmd.set_fin) begin
            r_res_label <= w_top;
            r_res_avg   <= w_top_score;
            r_res_new   <= w_fresh;
            r_res_err   <= 1'b0;
        end
        if (i_cmd.emit) begin
            r_m_tdata <= {4'd0, r_res_err, r_res_new, r_res_avg, r_res_label};
        end
    end

    assign m_axis_tvalid = r_m_tvalid;
    assign m_axis_tdata  = r_m_tdata;

endmodule

FILE: hw/rtl/keyword_score_smoother_core.sv
`timescale 1ns / 1ps

// Smooths keyword classifier scores over a sliding time window and flags new
// commands. One transaction in gives exactly one result transaction out; items
// are processed one at a time. Each item walks the entry queue, which has one
// read port, once for the age-out check and once for the sums of up to 32
// entries, then a 13-step restoring divider per class forms the four averages.
// An out-of-order item skips the queue walks and the divide; an undecided one
// skips the sums and the divide.
// A new item is taken while the previous result still waits.
module keyword_score_smoother_core (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    // [31:0] time_ms, [39:32] score_0, [47:40] score_1, [55:48] score_2, [63:56] score_3
    input  logic [63:0]                    s_axis_tdata,
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    // [1:0] label, [9:2] avg_score, [10] new_command, [11] order_error, [15:12] zero
    output logic [15:0]                    m_axis_tdata,
    input  logic                           i_cfg_we,
    input  logic [kss_pkg::CFG_ADDR_W-1:0] i_cfg_addr,
    input  logic [kss_pkg::CFG_DATA_W-1:0] i_cfg_wdata
);

    kss_pkg::t_kss_cmd w_cmd;
    kss_pkg::t_kss_sts w_sts;

    kss_ctrl u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .i_sts         (w_sts),
        .o_cmd         (w_cmd)
    );

    kss_dp u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_data     (s_axis_tdata),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_addr    (i_cfg_addr),
        .i_cfg_wdata   (i_cfg_wdata),
        .i_cmd         (w_cmd),
        .o_sts         (w_sts),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    a_emit_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.emit |-> (!m_axis_tvalid || m_axis_tready))
        else $error("result loaded over a pending transaction");

    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
        else $error("input taken while an item is in progress");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_sts.count <= kss_pkg::CNT_W'(kss_pkg::QUEUE_DEPTH))
        else $error("queue count beyond depth");

    a_rise_from_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(m_axis_tvalid) |-> $past(w_cmd.emit))
        else $error("output valid without a result");

endmodule

FILE: bench/kss_decision_checker.sv
`timescale 1ns / 1ps

module kss_decision_checker
    import kss_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_s_tvalid,
    input  logic                  i_s_tready,
    // [31:0] time_ms, [39:32] score_0, [47:40] score_1, [55:48] score_2, [63:56] score_3
    input  logic [63:0]           i_s_tdata,
    input  logic                  i_m_tvalid,
    input  logic                  i_m_tready,
    // [1:0] label, [9:2] avg_score, [10] new_command, [11] order_error, [15:12] zero
    input  logic [15:0]           i_m_tdata,
    input  logic                  i_cfg_we,
    input  logic [CFG_ADDR_W-1:0] i_cfg_addr,
    input  logic [CFG_DATA_W-1:0] i_cfg_wdata,
    output int                    o_fail_count,
    output int                    o_pending
);

    localparam int PEND_DEPTH = 64;

    typedef struct packed {
        logic       order_error;
        logic       new_command;
        logic [7:0] avg_score;
        logic [1:0] label;
    } t_decision;

    logic signed [31:0] held_tm [QUEUE_DEPTH];
    logic signed [7:0]  held_sc [QUEUE_DEPTH][NUM_CLASSES];
    int unsigned        oldest;
    int unsigned        held;
    logic [1:0]         cmd_label;
    longint             cmd_tm;
    logic [15:0]        win_ms;
    logic [5:0]         min_held;
    logic [15:0]        supp_ms;
    logic [7:0]         thr [NUM_CLASSES];
    int                 mismatches;
    t_decision          pend_q [PEND_DEPTH];
    int                 pend_rd;
    int                 pend_wr;
    int                 pend_cnt;

    function automatic t_decision smooth_and_detect(input logic [63:0] item);
        logic signed [31:0] tm_raw;
        longint             t_ms;
        longint             span;
        int unsigned        slot;
        int unsigned        idx;
        int unsigned        top;
        int unsigned        top_avg;
        int unsigned        avg;
        int unsigned        sum [NUM_CLASSES];
        t_decision          d;
        tm_raw = item[31:0];
        t_ms   = tm_raw;
        d      = '0;
        if (held > 0 && t_ms < held_tm[oldest]) begin
            d.order_error = 1'b1;
            return d;
        end
        if (held >= QUEUE_DEPTH) begin
            oldest = (oldest + 1) % QUEUE_DEPTH;
            held--;
        end
        slot = (oldest + held) % QUEUE_DEPTH;
        held_tm[slot] = tm_raw;
        for (int k = 0; k < NUM_CLASSES; k++)
            held_sc[slot][k] = item[32 + 8*k +: 8];
        held++;
        while (held > 0 && held_tm[oldest] < t_ms - longint'(win_ms)) begin
            oldest = (oldest + 1) % QUEUE_DEPTH;
            held--;
        end
        span = t_ms - held_tm[oldest];
        if (held < min_held || span < longint'(win_ms / 4)) begin
            d.label = cmd_label;
            return d;
        end
        for (int k = 0; k < NUM_CLASSES; k++)
            sum[k] = 0;
        idx = oldest;
        for (int unsigned n = 0; n < held; n++) begin
            for (int k = 0; k < NUM_CLASSES; k++)
                sum[k] += int'(held_sc[idx][k]) + 128;
            idx = (idx + 1) % QUEUE_DEPTH;
        end
        top     = 0;
        top_avg = 0;
        for (int k = 0; k < NUM_CLASSES; k++) begin
            avg = sum[k] / held;
            if (avg > top_avg) begin
                top_avg = avg;
                top     = k;
            end
        end
        if (top_avg > thr[top] &&
            (top != cmd_label || t_ms - cmd_tm > longint'(supp_ms))) begin
            cmd_label     = top[1:0];
            cmd_tm        = t_ms;
            d.new_command = 1'b1;
        end
        d.label     = top[1:0];
        d.avg_score = top_avg[7:0];
        return d;
    endfunction

    always @(posedge i_clk) begin
        t_decision want;
        t_decision got;
        if (!i_rst_n) begin
            oldest     = 0;
            held       = 0;
            cmd_label  = 2'd0;
            cmd_tm     = -(longint'(1) << 32);
            win_ms     = 16'd1000;
            min_held   = 6'd3;
            supp_ms    = 16'd1500;
            thr[0]     = 8'd200;
            thr[1]     = 8'd215;
            thr[2]     = 8'd180;
            thr[3]     = 8'd180;
            mismatches = 0;
            pend_rd    = 0;
            pend_wr    = 0;
            pend_cnt   = 0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_addr)
                    CFG_WINDOW:   win_ms   = i_cfg_wdata;
                    CFG_MIN:      min_held = i_cfg_wdata[5:0];
                    CFG_SUPPRESS: supp_ms  = i_cfg_wdata;
                    CFG_THR0:     thr[0]   = i_cfg_wdata[7:0];
                    CFG_THR1:     thr[1]   = i_cfg_wdata[7:0];
                    CFG_THR2:     thr[2]   = i_cfg_wdata[7:0];
                    CFG_THR3:     thr[3]   = i_cfg_wdata[7:0];
                    default: ;
                endcase
            end
            if (i_m_tvalid && i_m_tready) begin
                got = i_m_tdata[11:0];
                if (pend_cnt == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("[%0t] unexpected result transaction %h", $realtime,
                                 i_m_tdata);
                end else begin
                    want     = pend_q[pend_rd];
                    pend_rd  = (pend_rd + 1) % PEND_DEPTH;
                    pend_cnt = pend_cnt - 1;
                    if (got.label != want.label || got.avg_score != want.avg_score ||
                        got.new_command != want.new_command ||
                        got.order_error != want.order_error) begin
                        mismatches++;
                        if (mismatches <= 10) begin
                            $display("[%0t] mismatch exp lbl %0d avg %0d new %0b err %0b",
                                     $realtime, want.label, want.avg_score,
                                     want.new_command, want.order_error);
                            $display("[%0t] mismatch act lbl %0d avg %0d new %0b err %0b",
                                     $realtime, got.label, got.avg_score,
                                     got.new_command, got.order_error);
                        end
                    end
                end
            end
            if (i_s_tvalid && i_s_tready) begin
                if (pend_cnt == PEND_DEPTH) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("[%0t] too many transactions awaiting a result", $realtime);
                end else begin
                    pend_q[pend_wr] = smooth_and_detect(i_s_tdata);
                    pend_wr         = (pend_wr + 1) % PEND_DEPTH;
                    pend_cnt        = pend_cnt + 1;
                end
            end
        end
        o_fail_count <= mismatches;
        o_pending    <= pend_cnt;
    end

endmodule

FILE: bench/tb_keyword_score_smoother_core.sv
`timescale 1ns / 1ps

module tb_keyword_score_smoother_core;

    import kss_pkg::*;

    localparam longint T_MIN         = -64'sd2147483648;
    localparam longint T_MAX         = 64'sd2147483647;
    localparam logic [7:0] SC_MIN    = 8'h80;
    localparam logic [7:0] SC_MAX    = 8'h7F;
    localparam int     PHASES        = 8;
    localparam int     PHASE_ITEMS   = 56;
    localparam int     HOLD_CYCLES   = 300;
    localparam int     STUCK_LIMIT   = 4000;

    logic                  i_clk;
    logic                  i_rst_n       = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [63:0]           s_axis_tdata  = '0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [15:0]           m_axis_tdata;
    logic                  i_cfg_we      = 1'b0;
    logic [CFG_ADDR_W-1:0] i_cfg_addr    = '0;
    logic [CFG_DATA_W-1:0] i_cfg_wdata   = '0;

    int fail_count;
    int pending;
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    bit hold_req       = 1'b0;
    int stuck_cycles   = 0;

    keyword_score_smoother_core dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_addr    (i_cfg_addr),
        .i_cfg_wdata   (i_cfg_wdata)
    );

    kss_decision_checker checker_i (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_s_tvalid   (s_axis_tvalid),
        .i_s_tready   (s_axis_tready),
        .i_s_tdata    (s_axis_tdata),
        .i_m_tvalid   (m_axis_tvalid),
        .i_m_tready   (m_axis_tready),
        .i_m_tdata    (m_axis_tdata),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_addr   (i_cfg_addr),
        .i_cfg_wdata  (i_cfg_wdata),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // result side: random stalls, or one long hold-off when requested
    initial begin
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                hold_req = 1'b0;
                m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES - 1) @(negedge i_clk);
            end else begin
                m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            stuck_cycles <= 0;
        end else if (stuck_cycles == STUCK_LIMIT) begin
            $display("Verification failed");
            $finish;
        end else begin
            stuck_cycles <= stuck_cycles + 1;
        end
    end

    task automatic offer(input longint t_ms, input logic [3:0][7:0] scores);
        while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {scores, t_ms[31:0]};
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic drain(input int settle);
        s_axis_tvalid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (settle) @(negedge i_clk);
    endtask

    // upper data bits carry junk to check that narrow registers ignore them
    task automatic write_regs(input int win, input int mn, input int sup,
                              input logic [3:0][7:0] thr);
        i_cfg_we    <= 1'b1;
        i_cfg_addr  <= CFG_WINDOW;
        i_cfg_wdata <= win[15:0];
        @(negedge i_clk);
        i_cfg_addr  <= CFG_MIN;
        i_cfg_wdata <= {10'($urandom), mn[5:0]};
        @(negedge i_clk);
        i_cfg_addr  <= CFG_SUPPRESS;
        i_cfg_wdata <= sup[15:0];
        @(negedge i_clk);
        for (int k = 0; k < NUM_CLASSES; k++) begin
            i_cfg_addr  <= CFG_ADDR_W'(CFG_THR0 + k);
            i_cfg_wdata <= {8'($urandom), thr[k]};
            @(negedge i_clk);
        end
        i_cfg_we <= 1'b0;
    endtask

    function automatic logic [3:0][7:0] lead_scores(input int lead);
        logic [3:0][7:0] s;
        for (int k = 0; k < NUM_CLASSES; k++) begin
            if ($urandom_range(3) == 0)
                s[k] = 8'($urandom);
            else if (k == lead)
                s[k] = 8'($urandom_range(40, 127));
            else
                s[k] = 8'($urandom_range(128, 200));
        end
        return s;
    endfunction

    initial begin
        longint          cursor;
        longint          t_ms;
        int              win;
        int              mn;
        int              sup;
        int              lead;
        int              roll;
        logic [3:0][7:0] thr;

        repeat (3) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // reset settings: window 1000, min 3, suppress 1500
        offer(T_MIN,        {SC_MIN, SC_MIN, SC_MIN, SC_MIN});
        offer(T_MIN + 100,  {SC_MAX, SC_MAX, SC_MAX, SC_MAX});
        offer(T_MIN + 300,  {SC_MIN, SC_MAX, SC_MIN, SC_MIN});
        offer(T_MIN + 50,   {8'h00, 8'h00, 8'h00, 8'h00});
        offer(T_MIN + 1500, {SC_MIN, SC_MIN, SC_MIN, SC_MIN});
        offer(T_MIN + 1400, {SC_MAX, SC_MAX, SC_MAX, SC_MAX});
        offer(T_MIN,        {SC_MAX, SC_MAX, SC_MAX, SC_MAX});
        offer(T_MIN + 1600, {SC_MIN, SC_MIN, SC_MIN, SC_MAX});
        offer(T_MIN + 1800, {SC_MIN, SC_MIN, SC_MIN, SC_MAX});
        offer(T_MIN + 1900, {SC_MIN, SC_MIN, SC_MIN, SC_MAX});
        offer(T_MIN + 2000, {SC_MIN, SC_MIN, SC_MIN, SC_MAX});
        offer(T_MIN + 2100, {SC_MIN, SC_MIN, SC_MIN, SC_MAX});
        offer(T_MIN + 2200, {SC_MIN, SC_MIN, SC_MAX, SC_MIN});
        offer(T_MIN + 2300, {SC_MIN, SC_MIN, SC_MAX, SC_MIN});
        offer(T_MIN + 2400, {SC_MIN, SC_MIN, SC_MAX, SC_MIN});
        offer(T_MIN + 2600, {SC_MIN, SC_MIN, SC_MAX, SC_MIN});
        // tie between labels 1 and 3
        offer(T_MIN + 4000, {SC_MAX, 8'h00, SC_MAX, 8'h00});
        offer(T_MIN + 4100, {SC_MAX, 8'h00, SC_MAX, 8'h00});
        offer(T_MIN + 4300, {SC_MAX, 8'h00, SC_MAX, 8'h00});
        drain(16);

        // all-zero averages, then suppression exactly at the boundary
        write_regs(0, 1, 0, '0);
        offer(T_MIN + 5000, {SC_MIN, SC_MIN, SC_MIN, SC_MIN});
        offer(T_MIN + 5000, {SC_MIN, SC_MIN, SC_MIN, SC_MIN});
        offer(T_MIN + 5001, {8'h81, SC_MIN, SC_MIN, SC_MIN});
        offer(T_MIN + 5001, {8'h81, SC_MIN, SC_MIN, SC_MIN});
        offer(T_MIN + 5002, {8'h81, SC_MIN, SC_MIN, SC_MIN});

        cursor = T_MIN + 5002;
        lead   = 0;
        for (int ph = 0; ph < PHASES; ph++) begin
            drain(16);
            for (int k = 0; k < NUM_CLASSES; k++)
                thr[k] = 8'($urandom_range(150, 230));
            case (ph)
                0: begin win = 1000; mn = 3; sup = 1500; end
                1: begin win = 65535; mn = 32; sup = 0; thr = {8'd0, 8'd255, 8'd128, 8'd200}; end
                2: begin win = 0; mn = 1; sup = 65535; end
                3: begin
                    win = $urandom_range(100, 4000);
                    mn  = 0;
                    sup = $urandom_range(0, 3000);
                end
                4: begin win = 2000; mn = 63; sup = 1000; end
                5: begin win = 500; mn = 2; sup = 300; end
                6: begin
                    win = $urandom_range(0, 65535);
                    mn  = $urandom_range(1, 40);
                    sup = $urandom_range(0, 65535);
                    thr = $urandom;
                end
                default: begin
                    win = 65535;
                    mn  = 1;
                    sup = 65535;
                    thr = {8'd255, 8'd0, 8'd255, 8'd0};
                end
            endcase
            write_regs(win, mn, sup, thr);
            case (ph % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 46; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 46; end
                default: begin send_idle_pct = 11; recv_stall_pct = 11; end
            endcase
            if (ph == 1 || ph == 4)
                hold_req = 1'b1;
            cursor += 420_000_000 + $urandom_range(0, 50_000_000);

            for (int n = 0; n < PHASE_ITEMS; n++) begin
                roll = $urandom_range(99);
                if (roll < 6) begin
                    t_ms = cursor - win - 1 - $urandom_range(0, 100000);
                    if (t_ms < T_MIN)
                        t_ms = T_MIN;
                    offer(t_ms, $urandom);
                end else begin
                    if (roll < 10)
                        cursor += win + 1 + $urandom_range(0, 100000);
                    else
                        cursor += $urandom_range(0, (win >> $urandom_range(2, 7)) + 1);
                    if (cursor > T_MAX - 1_000_000)
                        cursor = T_MAX - 1_000_000;
                    if ($urandom_range(9) == 0)
                        lead = $urandom_range(3);
                    offer(cursor, lead_scores(lead));
                end
            end
        end

        offer(T_MAX, {SC_MAX, SC_MIN, SC_MAX, SC_MIN});
        offer(T_MAX, {SC_MAX, SC_MIN, SC_MAX, SC_MIN});
        offer(T_MIN, {SC_MIN, SC_MAX, SC_MIN, SC_MAX});
        drain(200);

        if (fail_count == 0 && pending == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
